// ===== design/rgb_convolution_3x3_macros.svh =====
// assertion helpers, clocked on i_clk, off while i_rst_n is low
`ifndef RGB_CONVOLUTION_3X3_MACROS_SVH
`define RGB_CONVOLUTION_3X3_MACROS_SVH

`define RGBC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RGBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rgbc_pkg.sv =====
package rgbc_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COL_W          = 10;
    localparam int ROW_W          = 12;
    localparam int WID_W          = 11;
    localparam int HGT_W          = 13;
    localparam int COEF_W         = 7;
    localparam int COEF_FRAC_BITS = 4;
    localparam int NTAPS          = 9;
    localparam int TAP_W          = 4;
    localparam int KERN_W         = 63;
    localparam int PIX_W          = 24;
    localparam int ACC_W          = 20;
    localparam int QUO_W          = 14;
    localparam int DIV_W          = 4;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_MAC,
        ST_POST,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef logic [2:0][QUO_W-1:0] t_quo;

    function automatic logic signed [COEF_W-1:0] tap_coef(
        input logic [KERN_W-1:0] kern,
        input logic [TAP_W-1:0]  tap
    );
        return kern[tap*COEF_W +: COEF_W];
    endfunction

endpackage

// ===== design/rgbc_div.sv =====
module rgbc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  rgbc_pkg::t_quo                  i_dividend,
    input  logic [rgbc_pkg::DIV_W-1:0]      i_divisor,
    output logic                            o_done,
    output rgbc_pkg::t_quo                  o_quot
);

    logic                          r_busy;
    logic [3:0]                    r_cnt;
    logic                          r_done;
    logic [rgbc_pkg::DIV_W-1:0]    r_d;
    logic [2:0][rgbc_pkg::DIV_W-1:0] r_rem;
    rgbc_pkg::t_quo                r_q;
    logic [2:0][rgbc_pkg::DIV_W-1:0] n_rem;
    rgbc_pkg::t_quo                n_q;

    always_comb begin
        logic [rgbc_pkg::DIV_W:0] t;
        for (int i = 0; i < 3; i++) begin
            t = {r_rem[i], r_q[i][rgbc_pkg::QUO_W-1]};
            if (t >= {1'b0, r_d}) begin
                n_rem[i] = rgbc_pkg::DIV_W'(t - {1'b0, r_d});
                n_q[i]   = {r_q[i][rgbc_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_rem[i] = t[rgbc_pkg::DIV_W-1:0];
                n_q[i]   = {r_q[i][rgbc_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(rgbc_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= (i_divisor == '0) ? rgbc_pkg::DIV_W'(1) : i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== design/rgb_convolution_3x3.sv =====
// Flow: an accepted pixel passes READ and SHIFT; a pixel in row 0 or column 0 then ends
// there, other border pixels go to EMIT, and interior pixels run MAC over the taps, POST,
// the serial divider (DIV) in clamp mode only, then EMIT, which waits on output stalls.
// A new pixel is taken only in IDLE; the line buffer read, the shared tap multipliers
// and the serial divider set the pace. Reset (synchronous, active low) clears state,
// counters, window and output valid, sets config registers to defaults, not line buffers.
`include "rgb_convolution_3x3_macros.svh"

module rgb_convolution_3x3 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // blue_in, green_in, red_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,   // col, row, blue, green, red
    output logic                                m_tlast,   // last_in_run
    output logic                                m_tuser,   // end_of_frame
    input  logic                                i_cfg_we,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rgbc_pkg::KERN_W-1:0]         i_cfg_data
);

    localparam int PW = rgbc_pkg::PIX_W;

    rgbc_pkg::t_state r_state, n_state;

    logic [rgbc_pkg::KERN_W-1:0] r_kernel;
    logic [rgbc_pkg::DIV_W-1:0]  r_divisor;
    logic                        r_clamp;
    logic                        r_bcopy;
    logic [rgbc_pkg::WID_W-1:0]  r_width;
    logic [rgbc_pkg::HGT_W-1:0]  r_height;

    logic [rgbc_pkg::COL_W-1:0]  r_colcnt;
    logic [rgbc_pkg::ROW_W-1:0]  r_rowcnt;
    logic [rgbc_pkg::COL_W-1:0]  r_col;
    logic [rgbc_pkg::ROW_W-1:0]  r_row;
    logic                        r_er, r_lr, r_int;
    logic [PW-1:0]               r_px;
    logic [PW-1:0]               r_win [rgbc_pkg::NTAPS];
    logic [rgbc_pkg::TAP_W-1:0]  r_tap;
    logic [2:0][rgbc_pkg::ACC_W-1:0] r_acc;
    logic [2:0]                  r_neg;
    logic [PW-1:0]               r_filt;
    logic [1:0]                  r_k;

    logic [2*PW-1:0]             mem [rgbc_pkg::MAX_WIDTH];
    logic [2*PW-1:0]             r_rd;

    logic                        r_mvalid, r_mlast, r_muser;
    logic [47:0]                 r_mdata;

    logic [rgbc_pkg::WID_W-1:0]  w_sat, wlast;
    logic [rgbc_pkg::HGT_W-1:0]  h_sat, hlast;
    logic [rgbc_pkg::COL_W-1:0]  col_sat;
    logic [rgbc_pkg::ROW_W-1:0]  row_sat;
    logic                        accept, load_out, div_start, div_done;
    rgbc_pkg::t_quo              div_in, div_q;
    logic [2:0][15:0]            trunc;
    logic [1:0]                  k_next;
    logic                        k_last;
    logic [PW-1:0]               res_px;
    logic [rgbc_pkg::ROW_W-1:0]  res_row;
    logic [rgbc_pkg::COL_W-1:0]  res_col;
    logic signed [rgbc_pkg::COEF_W-1:0] mac_coef;
    logic signed [15:0]          mac_prod [3];

    assign w_sat = (r_width < 11'd3) ? 11'd3 :
                   (r_width > 11'(rgbc_pkg::MAX_WIDTH)) ? 11'(rgbc_pkg::MAX_WIDTH) : r_width;
    assign h_sat = (r_height < 13'd3) ? 13'd3 :
                   (r_height > 13'(rgbc_pkg::MAX_HEIGHT)) ? 13'(rgbc_pkg::MAX_HEIGHT) : r_height;
    assign wlast = w_sat - 11'd1;
    assign hlast = h_sat - 13'd1;
    assign col_sat = ({1'b0, r_colcnt} > wlast) ? wlast[rgbc_pkg::COL_W-1:0] : r_colcnt;
    assign row_sat = ({1'b0, r_rowcnt} > hlast) ? hlast[rgbc_pkg::ROW_W-1:0] : r_rowcnt;

    assign s_tready = (r_state == rgbc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (r_state == rgbc_pkg::ST_EMIT) && (!r_mvalid || m_tready);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            trunc[i] = 16'((r_acc[i] + (r_acc[i][rgbc_pkg::ACC_W-1] ?
                       rgbc_pkg::ACC_W'((1 << rgbc_pkg::COEF_FRAC_BITS) - 1) : '0))
                       >> rgbc_pkg::COEF_FRAC_BITS);
            if (r_acc[i][rgbc_pkg::ACC_W-1])
                trunc[i] = trunc[i] | ~(16'hFFFF >> rgbc_pkg::COEF_FRAC_BITS);
            div_in[i] = trunc[i][rgbc_pkg::QUO_W-1:0];
        end
    end

    always_comb begin
        mac_coef = rgbc_pkg::tap_coef(r_kernel, r_tap);
        for (int c = 0; c < 3; c++) begin
            mac_prod[c] = $signed({{(16 - rgbc_pkg::COEF_W){mac_coef[rgbc_pkg::COEF_W-1]}},
                                   mac_coef}) *
                          $signed({8'd0, r_win[r_tap][c*8 +: 8]});
        end
    end

    always_comb begin
        case (r_k)
            2'd0: begin
                k_last = !(r_er || r_lr);
                k_next = r_er ? 2'd1 : 2'd2;
            end
            2'd1: begin
                k_last = !r_lr;
                k_next = 2'd2;
            end
            2'd2: begin
                k_last = !r_er;
                k_next = 2'd3;
            end
            default: begin
                k_last = 1'b1;
                k_next = 2'd3;
            end
        endcase
    end

    always_comb begin
        case (r_k)
            2'd0: begin
                res_row = r_row - 12'd1;
                res_col = r_col - 10'd1;
                res_px  = r_int ? r_filt : (r_bcopy ? r_win[4] : {PW{1'b1}});
            end
            2'd1: begin
                res_row = r_row - 12'd1;
                res_col = r_col;
                res_px  = r_bcopy ? r_win[5] : {PW{1'b1}};
            end
            2'd2: begin
                res_row = r_row;
                res_col = r_col - 10'd1;
                res_px  = r_bcopy ? r_win[7] : {PW{1'b1}};
            end
            default: begin
                res_row = r_row;
                res_col = r_col;
                res_px  = r_bcopy ? r_win[8] : {PW{1'b1}};
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            rgbc_pkg::ST_IDLE:  if (accept) n_state = rgbc_pkg::ST_READ;
            rgbc_pkg::ST_READ:  n_state = rgbc_pkg::ST_SHIFT;
            rgbc_pkg::ST_SHIFT: begin
                if (r_row == '0 || r_col == '0)
                    n_state = rgbc_pkg::ST_IDLE;
                else if (r_int)
                    n_state = rgbc_pkg::ST_MAC;
                else
                    n_state = rgbc_pkg::ST_EMIT;
            end
            rgbc_pkg::ST_MAC: begin
                if (r_tap == 4'(rgbc_pkg::NTAPS - 1)) n_state = rgbc_pkg::ST_POST;
            end
            rgbc_pkg::ST_POST: begin
                if (r_clamp) begin
                    div_start = 1'b1;
                    n_state   = rgbc_pkg::ST_DIV;
                end else begin
                    n_state = rgbc_pkg::ST_EMIT;
                end
            end
            rgbc_pkg::ST_DIV:   if (div_done) n_state = rgbc_pkg::ST_EMIT;
            rgbc_pkg::ST_EMIT:  if (load_out && k_last) n_state = rgbc_pkg::ST_IDLE;
            default:            n_state = rgbc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rgbc_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel  <= '0;
            r_divisor <= 4'd1;
            r_clamp   <= 1'b1;
            r_bcopy   <= 1'b1;
            r_width   <= 11'(rgbc_pkg::MAX_WIDTH);
            r_height  <= 13'(rgbc_pkg::MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rgbc_pkg::CFG_KERNEL:  r_kernel  <= i_cfg_data;
                rgbc_pkg::CFG_DIVISOR: r_divisor <= i_cfg_data[rgbc_pkg::DIV_W-1:0];
                rgbc_pkg::CFG_CLAMP:   r_clamp   <= i_cfg_data[0];
                rgbc_pkg::CFG_BORDER:  r_bcopy   <= i_cfg_data[0];
                rgbc_pkg::CFG_WIDTH:   r_width   <= i_cfg_data[rgbc_pkg::WID_W-1:0];
                rgbc_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data[rgbc_pkg::HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_rd <= mem[col_sat];
        if (r_state == rgbc_pkg::ST_SHIFT) mem[r_col] <= {r_rd[PW-1:0], r_px};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colcnt <= '0;
            r_rowcnt <= '0;
            for (int i = 0; i < rgbc_pkg::NTAPS; i++) r_win[i] <= '0;
        end else if (r_state == rgbc_pkg::ST_SHIFT) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3]     <= r_win[k*3+1];
                r_win[k*3 + 1] <= r_win[k*3+2];
            end
            r_win[2] <= r_rd[2*PW-1:PW];
            r_win[5] <= r_rd[PW-1:0];
            r_win[8] <= r_px;
            if (r_er) begin
                r_colcnt <= '0;
                r_rowcnt <= r_lr ? '0 : r_row + 12'd1;
            end else begin
                r_colcnt <= r_col + 10'd1;
                r_rowcnt <= r_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px  <= s_tdata;
            r_col <= col_sat;
            r_row <= row_sat;
            r_er  <= (col_sat == wlast[rgbc_pkg::COL_W-1:0]);
            r_lr  <= (row_sat == hlast[rgbc_pkg::ROW_W-1:0]);
            r_int <= (row_sat >= 12'd2) && (col_sat >= 10'd2);
        end
        case (r_state)
            rgbc_pkg::ST_SHIFT: begin
                r_tap <= '0;
                r_acc <= '0;
                r_k   <= 2'd0;
            end
            rgbc_pkg::ST_MAC: begin
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= r_acc[c] + rgbc_pkg::ACC_W'(mac_prod[c]);
                end
                r_tap <= r_tap + 4'd1;
            end
            rgbc_pkg::ST_POST: begin
                for (int c = 0; c < 3; c++) begin
                    r_neg[c]         <= r_acc[c][rgbc_pkg::ACC_W-1];
                    r_filt[c*8 +: 8] <= trunc[c][7:0];
                end
            end
            rgbc_pkg::ST_DIV: begin
                if (div_done) begin
                    for (int c = 0; c < 3; c++) begin
                        if (r_neg[c])
                            r_filt[c*8 +: 8] <= 8'd0;
                        else if (div_q[c] > 14'd255)
                            r_filt[c*8 +: 8] <= 8'd255;
                        else
                            r_filt[c*8 +: 8] <= div_q[c][7:0];
                    end
                end
            end
            rgbc_pkg::ST_EMIT: begin
                if (load_out) r_k <= k_next;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (load_out) begin
            r_mvalid <= 1'b1;
        end else if (m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_mdata <= {2'b00, res_col, res_row, res_px};
            r_mlast <= k_last;
            r_muser <= (r_k == 2'd3);
        end
    end

    rgbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_in),
        .i_divisor  (r_divisor),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tlast  = r_mlast;
    assign m_tuser  = r_muser;

    `RGBC_ASSERT_SAME(a_eof_is_last, r_mvalid && r_muser, r_mlast, "end of frame not last")
    `RGBC_ASSERT_NEXT(a_accept_reads, accept, r_state == rgbc_pkg::ST_READ, "no read")
    `RGBC_ASSERT_SAME(a_tap_range, r_state == rgbc_pkg::ST_MAC, r_tap <= 4'd8, "tap overrun")
    `RGBC_ASSERT_SAME(a_shift_after_read, r_state == rgbc_pkg::ST_SHIFT, $past(r_state) == rgbc_pkg::ST_READ, "no read")

endmodule
